>>> sv/ppmq_pkg.sv
`default_nettype none
package ppmq_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [15:0] DIM_MAX    = 16'hFFFF;
  localparam logic [8:0]  LEVEL_SAT  = 9'd256;
  localparam logic [8:0]  LEVEL_MAX  = 9'd255;
  localparam logic [2:0]  RG_LEVELS  = 3'd7;
  localparam logic [2:0]  B_LEVELS   = 3'd3;
  localparam logic [1:0]  COMP_RED   = 2'd0;
  localparam logic [1:0]  COMP_GREEN = 2'd1;
  localparam logic [1:0]  COMP_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // work handed from the parser to the quantizer
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_ERROR  = 2'd1,
    OP_COMP   = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic [1:0]  comp;
    logic [7:0]  sample;
    logic [7:0]  maxval;
    logic [15:0] width;
    logic [15:0] height;
  } op_t;

endpackage
`default_nettype wire

>>> sv/ppmq_front.sv
`default_nettype none
module ppmq_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire ppmq_pkg::in_t  in_data_i,
  output logic                op_valid_o,
  output ppmq_pkg::op_t       op_o
);

  typedef enum logic [5:0] {
    PH_MAGIC  = 6'b000001,
    PH_WIDTH  = 6'b000010,
    PH_HEIGHT = 6'b000100,
    PH_MAXVAL = 6'b001000,
    PH_PIXELS = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  magic_q, magic_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [8:0]  maxl_q, maxl_d;
  logic [1:0]  comp_q, comp_d;

  logic [7:0]  b;
  logic [3:0]  digit;
  logic        is_digit;
  logic [7:0]  expect_ch;
  logic [19:0] wide_w, wide_h;
  logic [12:0] wide_m;
  logic        fail, hdr, emit_comp, eof_err;
  logic [7:0]  clamped;

  assign b        = in_data_i.data_byte;
  assign is_digit = (b >= ppmq_pkg::CHAR_ZERO) && (b <= ppmq_pkg::CHAR_NINE);
  assign digit    = 4'(b - ppmq_pkg::CHAR_ZERO);

  // acc*10 + digit, as (acc<<3) + (acc<<1)
  assign wide_w = {1'b0, width_q, 3'b000} + {3'b000, width_q, 1'b0} + {16'd0, digit};
  assign wide_h = {1'b0, height_q, 3'b000} + {3'b000, height_q, 1'b0} + {16'd0, digit};
  assign wide_m = {1'b0, maxl_q, 3'b000} + {3'b000, maxl_q, 1'b0} + {9'd0, digit};

  assign clamped = (b > maxl_q[7:0]) ? maxl_q[7:0] : b;

  always_comb begin
    case (magic_q)
      2'd0:    expect_ch = ppmq_pkg::CHAR_P;
      2'd1:    expect_ch = ppmq_pkg::CHAR_SIX;
      default: expect_ch = ppmq_pkg::CHAR_NL;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    magic_d   = magic_q;
    width_d   = width_q;
    height_d  = height_q;
    maxl_d    = maxl_q;
    comp_d    = comp_q;
    fail      = 1'b0;
    hdr       = 1'b0;
    emit_comp = 1'b0;
    eof_err   = 1'b0;

    case (phase_q)
      PH_MAGIC: begin
        if (b != expect_ch) begin
          fail = 1'b1;
        end else if (magic_q >= 2'd2) begin
          phase_d = PH_WIDTH;
          magic_d = 2'd0;
        end else begin
          magic_d = magic_q + 2'd1;
        end
      end
      PH_WIDTH: begin
        if (is_digit) begin
          width_d = (wide_w > {4'd0, ppmq_pkg::DIM_MAX}) ? ppmq_pkg::DIM_MAX : wide_w[15:0];
        end else if (b == ppmq_pkg::CHAR_SPACE) begin
          phase_d = PH_HEIGHT;
        end else begin
          fail = 1'b1;
        end
      end
      PH_HEIGHT: begin
        if (is_digit) begin
          height_d = (wide_h > {4'd0, ppmq_pkg::DIM_MAX}) ? ppmq_pkg::DIM_MAX : wide_h[15:0];
        end else if (b == ppmq_pkg::CHAR_NL) begin
          phase_d = PH_MAXVAL;
        end else begin
          fail = 1'b1;
        end
      end
      PH_MAXVAL: begin
        if (is_digit) begin
          maxl_d = (wide_m > {4'd0, ppmq_pkg::LEVEL_SAT}) ? ppmq_pkg::LEVEL_SAT : wide_m[8:0];
        end else if ((b == ppmq_pkg::CHAR_NL) && (maxl_q <= ppmq_pkg::LEVEL_MAX)) begin
          phase_d = PH_PIXELS;
          hdr     = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      PH_PIXELS: begin
        emit_comp = 1'b1;
        comp_d    = (comp_q == ppmq_pkg::COMP_BLUE) ? ppmq_pkg::COMP_RED : comp_q + 2'd1;
      end
      default: begin
      end
    endcase

    if (fail) begin
      phase_d = PH_IGNORE;
    end

    // file ended while the header was still open
    if (in_data_i.end_of_file && !fail && !hdr &&
        (phase_q == PH_MAGIC || phase_q == PH_WIDTH ||
         phase_q == PH_HEIGHT || phase_q == PH_MAXVAL)) begin
      eof_err = 1'b1;
    end

    if (in_data_i.end_of_file) begin
      phase_d  = PH_MAGIC;
      magic_d  = 2'd0;
      width_d  = '0;
      height_d = '0;
      maxl_d   = '0;
      comp_d   = ppmq_pkg::COMP_RED;
    end
  end

  always_comb begin
    op_valid_o   = accept_i && (fail || hdr || emit_comp || eof_err);
    op_o         = '0;
    op_o.comp    = comp_q;
    op_o.sample  = clamped;
    op_o.maxval  = maxl_q[7:0];
    op_o.width   = width_q;
    op_o.height  = height_q;
    if (hdr) begin
      op_o.op = ppmq_pkg::OP_HEADER;
    end else if (emit_comp) begin
      op_o.op = ppmq_pkg::OP_COMP;
    end else begin
      op_o.op = ppmq_pkg::OP_ERROR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      magic_q  <= 2'd0;
      width_q  <= '0;
      height_q <= '0;
      maxl_q   <= '0;
      comp_q   <= ppmq_pkg::COMP_RED;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      magic_q  <= magic_d;
      width_q  <= width_d;
      height_q <= height_d;
      maxl_q   <= maxl_d;
      comp_q   <= comp_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/ppmq_fifo.sv
`default_nettype none
module ppmq_fifo #(
  parameter int unsigned Depth = ppmq_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire ppmq_pkg::op_t  wr_data_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output logic                empty_o,
  output ppmq_pkg::op_t       rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ppmq_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/ppmq_back.sv
`default_nettype none
module ppmq_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           op_empty_i,
  input  wire ppmq_pkg::op_t  op_i,
  output logic                op_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output ppmq_pkg::out_t      out_data_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_FIN  = 3'b100
  } bstate_e;

  bstate_e        st_q, st_d;
  logic [11:0]    rem_q, rem_d;
  logic [11:0]    dsr_q, dsr_d;
  logic [2:0]     quo_q, quo_d;
  logic [1:0]     step_q, step_d;
  logic [1:0]     comp_q, comp_d;
  logic [5:0]     part_q, part_d;
  logic           out_valid_q, out_valid_d;
  ppmq_pkg::out_t out_q, out_d;

  logic        slot_free, load_out;
  logic [2:0]  n;
  logic [11:0] c_w, m_w, n_w, num, prod;
  logic [9:0]  den;
  logic        ge;
  logic [11:0] diff;

  assign slot_free = !out_valid_q || pop_i;

  // rescale setup: divide num by den, quotient always fits in 0..n
  always_comb begin
    n    = (op_i.comp == ppmq_pkg::COMP_BLUE) ? ppmq_pkg::B_LEVELS : ppmq_pkg::RG_LEVELS;
    c_w  = {4'd0, op_i.sample};
    m_w  = {4'd0, op_i.maxval};
    n_w  = {9'd0, n};
    prod = c_w * n_w;
    if (op_i.maxval == '0) begin
      num = n_w;
      den = 10'd1;
    end else if (m_w <= n_w) begin
      num = {prod[10:0], 1'b0} + m_w;
      den = {1'b0, op_i.maxval, 1'b0};
    end else begin
      num = ((op_i.comp == ppmq_pkg::COMP_BLUE) ? {c_w[8:0], 3'b000}
                                                : {c_w[7:0], 4'b0000}) + n_w;
      den = {({1'b0, op_i.maxval} + 9'd1), 1'b0};
    end
  end

  assign ge   = rem_q >= dsr_q;
  assign diff = rem_q - dsr_q;

  always_comb begin
    st_d     = st_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    quo_d    = quo_q;
    step_d   = step_q;
    comp_d   = comp_q;
    part_d   = part_q;
    op_pop_o = 1'b0;
    load_out = 1'b0;
    out_d    = out_q;

    case (st_q)
      B_IDLE: begin
        if (!op_empty_i) begin
          case (op_i.op)
            ppmq_pkg::OP_COMP: begin
              op_pop_o = 1'b1;
              rem_d    = num;
              dsr_d    = {den, 2'b00};
              quo_d    = '0;
              step_d   = '0;
              comp_d   = op_i.comp;
              st_d     = B_DIV;
            end
            ppmq_pkg::OP_HEADER: begin
              if (slot_free) begin
                op_pop_o           = 1'b1;
                load_out           = 1'b1;
                out_d              = '0;
                out_d.kind         = ppmq_pkg::KIND_HEADER;
                out_d.image_width  = op_i.width;
                out_d.image_height = op_i.height;
              end
            end
            default: begin
              if (slot_free) begin
                op_pop_o   = 1'b1;
                load_out   = 1'b1;
                out_d      = '0;
                out_d.kind = ppmq_pkg::KIND_ERROR;
              end
            end
          endcase
        end
      end
      B_DIV: begin
        if (ge) begin
          rem_d = diff;
        end
        quo_d  = {quo_q[1:0], ge};
        dsr_d  = {1'b0, dsr_q[11:1]};
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          st_d = B_FIN;
        end
      end
      B_FIN: begin
        case (comp_q)
          ppmq_pkg::COMP_RED: begin
            part_d = {quo_q, 3'b000};
            st_d   = B_IDLE;
          end
          ppmq_pkg::COMP_GREEN: begin
            part_d = {part_q[5:3], quo_q};
            st_d   = B_IDLE;
          end
          default: begin
            if (slot_free) begin
              load_out    = 1'b1;
              out_d       = '0;
              out_d.kind  = ppmq_pkg::KIND_PIXEL;
              out_d.pixel = {quo_q[1:0], part_q};
              st_d        = B_IDLE;
            end
          end
        endcase
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase

    out_valid_d = load_out || (out_valid_q && !pop_i);
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      comp_q      <= ppmq_pkg::COMP_RED;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      comp_q      <= comp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quo_q  <= quo_d;
    part_q <= part_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

>>> sv/ppm_raw_to_rgb332_stream.sv
// Raw PPM (P6) byte stream to packed 3-3-2 pixel stream.
// Input side is a queue write port: present one file byte on in_data_i with
// push_i; the transaction happens when push_i is high and full_o is low.
// end_of_file marks the last byte of a file; the parser then starts over.
// Result side is a queue read port: while empty_o is low the oldest result
// sits on out_data_o, and pop_i takes it. kind tells header (width, height),
// pixel, or error; unused fields read zero.
// A parser front end classifies each byte in the cycle it is taken and posts
// work into a short queue; the quantizer back end drains it.
// Header/error results pass through the queue and then the output register
// on their way to out_data_o. The back end handles one color sample at a
// time, in steps (load, 3 restoring divide steps, finish), and the pixel
// result enters the output register in the blue sample's finish step once
// that register is free; header bytes flow at one per cycle while the queue has room.
// When the receiver stalls, the output register and queue fill and full_o
// rises; nothing is lost. Reset empties queue and output, parser expects "P6".
`default_nettype none
module ppm_raw_to_rgb332_stream #(
  parameter int unsigned QueueDepth = ppmq_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire ppmq_pkg::in_t   in_data_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output ppmq_pkg::out_t       out_data_o
);

  logic          accept;
  logic          op_valid;
  ppmq_pkg::op_t op_wr;
  ppmq_pkg::op_t op_rd;
  logic          q_empty;
  logic          q_pop;

  // the front end always posts at most one op per byte, so queue room
  // alone gates the input transaction
  assign accept = push_i && !full_o;

  ppmq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_o       (op_wr)
  );

  ppmq_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (op_valid),
    .wr_data_i (op_wr),
    .full_o    (full_o),
    .rd_i      (q_pop),
    .empty_o   (q_empty),
    .rd_data_o (op_rd)
  );

  ppmq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (q_empty),
    .op_i       (op_rd),
    .op_pop_o   (q_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_ppm_raw_to_rgb332_stream.sv
`timescale 1ns / 100ps
module tb_ppm_raw_to_rgb332_stream;
  import ppmq_pkg::*;

  // Stop stimulus once this many bytes have been taken outside the skip-to-EOF phase.
  localparam int unsigned TARGET_BYTES = 1350;
  // Slowest legal run: ~1500 bytes, each after the longest gap and the back end's
  // work, plus ~600 results each after the longest stall, plus the pressure hold.
  // Allow five times that.
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned DRAIN_TAIL   = 64;   // quiet tail after the owed results are in
  localparam int unsigned PRESSURE_HOLD = 400;

  // Local copy of the parser phases.
  typedef enum logic [2:0] {
    PARSE_MAGIC,
    PARSE_WIDTH,
    PARSE_HEIGHT,
    PARSE_MAXVAL,
    PARSE_PIXELS,
    PARSE_IGNORE
  } parse_phase_e;

  logic  clk_i;
  logic  rst_ni;
  logic  push_i;
  logic  full_o;
  in_t   in_data_i;
  logic  empty_o;
  logic  pop_i;
  out_t  out_data_o;

  ppm_raw_to_rgb332_stream uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_data_i  (in_data_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: header parse and 3-3-2 quantize, one byte per call.
  // ---------------------------------------------------------------------------
  parse_phase_e phase;
  logic [1:0]   magic_pos;
  int unsigned  width_acc;
  int unsigned  height_acc;
  int unsigned  level_max;     // saturates at LEVEL_SAT
  logic [1:0]   comp_idx;
  logic [7:0]   rg_bits;       // red and green gathered for the current triple

  out_t        decoded_q[$];   // results owed by the block, oldest first
  logic [7:0]  file_bytes[$];  // file under construction
  int unsigned bytes_counted;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          tx_steady;
  bit          rx_steady;
  int unsigned rx_hold;        // receiver hold-off request, counted down by the drain process

  task automatic clear_decoder();
    phase      = PARSE_MAGIC;
    magic_pos  = '0;
    width_acc  = 0;
    height_acc = 0;
    level_max  = 0;
    comp_idx   = COMP_RED;
    rg_bits    = '0;
  endtask

  function automatic bit is_digit(logic [7:0] b);
    return b >= CHAR_ZERO && b <= CHAR_NINE;
  endfunction

  function automatic int unsigned add_digit(int unsigned acc, logic [7:0] b, int unsigned cap);
    int unsigned v;
    v = acc * 10 + (b - CHAR_ZERO);
    return (v > cap) ? cap : v;
  endfunction

  // Map sample c from 0..m onto 0..n; samples above m clamp to m.
  function automatic int unsigned rescale(int unsigned c, int unsigned m, int unsigned n);
    int unsigned s;
    s = (c > m) ? m : c;
    if (n >= m)
      return (m == 0) ? n : (2 * s * n + m) / (2 * m);
    return (2 * s * (n + 1) + n) / (2 * (m + 1));
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    out_t       r;
    bit         emit;
    bit         bad;
    logic [7:0] want;
    r    = '0;
    emit = 1'b0;
    bad  = 1'b0;
    case (phase)
      PARSE_MAGIC: begin
        want = (magic_pos == 2'd0) ? CHAR_P : (magic_pos == 2'd1) ? CHAR_SIX : CHAR_NL;
        if (b != want) bad = 1'b1;
        else if (magic_pos == 2'd2) begin
          phase     = PARSE_WIDTH;
          magic_pos = '0;
        end else magic_pos = magic_pos + 2'd1;
      end
      PARSE_WIDTH: begin
        if (is_digit(b)) width_acc = add_digit(width_acc, b, DIM_MAX);
        else if (b == CHAR_SPACE) phase = PARSE_HEIGHT;
        else bad = 1'b1;
      end
      PARSE_HEIGHT: begin
        if (is_digit(b)) height_acc = add_digit(height_acc, b, DIM_MAX);
        else if (b == CHAR_NL) phase = PARSE_MAXVAL;
        else bad = 1'b1;
      end
      PARSE_MAXVAL: begin
        if (is_digit(b)) level_max = add_digit(level_max, b, LEVEL_SAT);
        else if (b == CHAR_NL && level_max <= LEVEL_MAX) begin
          phase            = PARSE_PIXELS;
          emit             = 1'b1;
          r.kind           = KIND_HEADER;
          r.image_width    = 16'(width_acc);
          r.image_height   = 16'(height_acc);
        end else bad = 1'b1;
      end
      PARSE_PIXELS: begin
        if (comp_idx == COMP_RED) begin
          rg_bits  = 8'(rescale(b, level_max, RG_LEVELS) << 3);
          comp_idx = COMP_GREEN;
        end else if (comp_idx == COMP_GREEN) begin
          rg_bits  = rg_bits | 8'(rescale(b, level_max, RG_LEVELS));
          comp_idx = COMP_BLUE;
        end else begin
          r.kind   = KIND_PIXEL;
          r.pixel  = 8'(rescale(b, level_max, B_LEVELS) << 6) | rg_bits;
          rg_bits  = '0;
          comp_idx = COMP_RED;
          emit     = 1'b1;
        end
      end
      default: ;
    endcase

    if (bad) begin
      phase  = PARSE_IGNORE;
      emit   = 1'b1;
      r      = '0;
      r.kind = KIND_ERROR;
    end else if (eof && !emit && phase <= PARSE_MAXVAL) begin
      // file cut short inside the header
      emit   = 1'b1;
      r.kind = KIND_ERROR;
    end
    if (eof) clear_decoder();
    if (emit) decoded_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Traffic shaping: mostly zero or short gaps, now and then a long one.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // One byte transaction. push_i is only lowered when a gap follows, so
  // back-to-back bytes keep it high across the edge.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_data_i <= '{data_byte: b, end_of_file: eof};
    do @(posedge clk_i); while (full_o);
    if (phase != PARSE_IGNORE) bytes_counted++;
    decode_byte(b, eof);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  task automatic append_digits(input int unsigned len);
    repeat (len) file_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  function automatic int unsigned pick_dim_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;                       // empty number reads as zero
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 7);                // can push past 65535
  endfunction

  function automatic logic [7:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    if (r < 30) return 8'($urandom_range(0, 15));
    return 8'($urandom);
  endfunction

  // Mostly well-formed files with random content; the rest is noise,
  // a corrupted header byte, or a file cut off early.
  task automatic build_random_file();
    int unsigned r;
    int unsigned hdr_len;
    int unsigned triples;
    int unsigned cut;
    file_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom));
      return;
    end

    append_text("P6\n");
    append_digits(pick_dim_len());
    file_bytes.push_back(CHAR_SPACE);
    append_digits(pick_dim_len());
    file_bytes.push_back(CHAR_NL);
    r = $urandom_range(0, 99);
    if (r < 60)      append_text($sformatf("%0d", $urandom_range(0, 255)));
    else if (r < 75) append_text($sformatf("%0d", $urandom_range(0, 7)));
    else if (r < 83) append_text($sformatf("0%0d", $urandom_range(0, 255)));
    else if (r < 90) append_text($sformatf("%0d", $urandom_range(256, 999)));
    else             append_digits($urandom_range(0, 5));
    file_bytes.push_back(CHAR_NL);
    hdr_len = file_bytes.size();

    triples = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
    repeat (3 * triples) file_bytes.push_back(pick_sample());
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) file_bytes.push_back(pick_sample());

    r = $urandom_range(0, 99);
    if (r < 10) begin
      file_bytes[$urandom_range(0, hdr_len - 1)] = 8'($urandom);
    end else if (r < 18) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked files: empty numbers with maxval zero, clamping of samples
  // above maxval plus a dropped partial triple, a bad magic byte, and a
  // maxval that is too large.
  task automatic test_directed_files();
    file_bytes.delete();
    append_text("P6\n \n0\n");
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h09);
    send_file();

    file_bytes.delete();
    append_text("P6\n \n9\n");
    file_bytes.push_back(8'd200);
    file_bytes.push_back(8'd9);
    file_bytes.push_back(8'd0);
    file_bytes.push_back(8'd4);   // trailing partial triple
    send_file();

    file_bytes.delete();
    append_text("Q");
    send_file();

    file_bytes.delete();
    append_text("P6\n \n300\n");
    send_file();
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing,
  // so the block backs up and raises full_o.
  task automatic test_output_backpressure();
    file_bytes.delete();
    append_text("P6\n64 1\n255\n");
    repeat (3 * 64) file_bytes.push_back(pick_sample());
    tx_steady = 1'b1;
    rx_hold   = PRESSURE_HOLD;
    send_file();
    tx_steady = 1'b0;
  endtask

  task automatic test_random_files();
    int unsigned files;
    files = 0;
    while (bytes_counted < TARGET_BYTES) begin
      // switch between idling and back-to-back stretches every few files
      if (files % 6 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      build_random_file();
      send_file();
      files++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each popped transaction, then decide pop for next edge.
  // ---------------------------------------------------------------------------
  task automatic check_result(input out_t got);
    out_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected result kind=%0d pixel=%02h w=%0d h=%0d", $time,
               got.kind, got.pixel, got.image_width, got.image_height);
      fail_count++;
      return;
    end
    want = decoded_q.pop_front();
    if (got.kind != want.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      fail_count++;
    end
    if (got.pixel != want.pixel) begin
      $display("%0t: pixel expected %02h actual %02h", $time, want.pixel, got.pixel);
      fail_count++;
    end
    if (got.image_width != want.image_width) begin
      $display("%0t: image_width expected %0d actual %0d", $time,
               want.image_width, got.image_width);
      fail_count++;
    end
    if (got.image_height != want.image_height) begin
      $display("%0t: image_height expected %0d actual %0d", $time,
               want.image_height, got.image_height);
      fail_count++;
    end
  endtask

  initial begin : result_drain
    int unsigned stall_left;
    stall_left = 0;
    pop_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop_i && !empty_o) check_result(out_data_o);
      if (rx_hold > 0) begin
        rx_hold--;
        pop_i <= 1'b0;
      end else if (rx_steady) begin
        pop_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        pop_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        pop_i <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d results still owed", $time, decoded_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    push_i        <= 1'b0;
    in_data_i     <= '0;
    bytes_counted = 0;
    fail_count    = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rx_hold       = 0;
    clear_decoder();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_files();
    test_output_backpressure();
    test_random_files();
    push_i <= 1'b0;

    // all bytes are in; wait for the owed results, then a quiet tail
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ppmq_pkg.sv
sv/ppmq_front.sv
sv/ppmq_fifo.sv
sv/ppmq_back.sv
sv/ppm_raw_to_rgb332_stream.sv
tb/tb_ppm_raw_to_rgb332_stream.sv
